// ----- rtl/core/dst_pkg.sv -----
// ----------------------------------------------------------------------------
// Dither seam tracker package
// Shared constants, codes and the sine table of the scan controller.
// ----------------------------------------------------------------------------
package dst_pkg;

	localparam int NPHASE   = 20;
	localparam int PH_W     = 5;
	localparam int AMP_W    = 11;
	localparam int THR_W    = 12;
	localparam int SPA_W    = 8;
	localparam int DAC_W    = 12;
	localparam int CTR_W    = 9;
	localparam int AVG_W    = 12;
	localparam int HIT_W    = 9;
	localparam int MV_W     = 2;
	localparam int PSUM_W   = 17;
	localparam int AN_W     = 18;
	localparam int DSUM_W   = 38;
	localparam int DX_W     = 23;
	localparam int SINE_W   = 16;
	localparam int SPROD_W  = 27;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_AMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPA = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [MV_W-1:0] MV_NONE = 2'b00;
	localparam logic [MV_W-1:0] MV_UP   = 2'b01;
	localparam logic [MV_W-1:0] MV_DOWN = 2'b11;

	localparam logic [CTR_W-1:0] CENTER_MAX   = 9'd330;
	localparam logic [CTR_W-1:0] CENTER_RESET = 9'd160;
	localparam logic [HIT_W-1:0] HITS_MAX     = 9'd511;
	localparam logic [CTR_W-1:0] DAC_DIVISOR  = 9'd330;
	localparam logic [DX_W-1:0]  DAC_SAT_X    = 23'd1351680;
	localparam logic [DAC_W-1:0] DAC_TOP      = 12'd4095;
	localparam logic [PH_W-1:0]  PH_LAST      = 5'd19;
	localparam logic [PH_W-1:0]  PH_HALF      = 5'd10;
	localparam logic [PH_W-1:0]  PH_PROBE     = 5'd8;

	localparam logic [AMP_W-1:0] AMP_RESET = 11'd64;
	localparam logic [THR_W-1:0] THR_RESET = 12'd120;
	localparam logic [SPA_W-1:0] SPA_RESET = 8'd25;

	// sin(k * 0.314) in Q1.15
	function automatic logic signed [SINE_W-1:0] sine_q15(input logic [PH_W-1:0] ph);
		logic signed [SINE_W-1:0] v;
		case (ph)
			5'd0:    v = 16'sd0;
			5'd1:    v = 16'sd10121;
			5'd2:    v = 16'sd19252;
			5'd3:    v = 16'sd26501;
			5'd4:    v = 16'sd31158;
			5'd5:    v = 16'sd32767;
			5'd6:    v = 16'sd31174;
			5'd7:    v = 16'sd26531;
			5'd8:    v = 16'sd19294;
			5'd9:    v = 16'sd10171;
			5'd10:   v = 16'sd52;
			5'd11:   v = -16'sd10071;
			5'd12:   v = -16'sd19210;
			5'd13:   v = -16'sd26470;
			5'd14:   v = -16'sd31142;
			5'd15:   v = -16'sd32767 - 16'sd1;
			5'd16:   v = -16'sd31190;
			5'd17:   v = -16'sd26562;
			5'd18:   v = -16'sd19336;
			5'd19:   v = -16'sd10220;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/dst_if.sv -----
// ----------------------------------------------------------------------------
// Dither seam tracker channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface dst_item_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output opcode, output sample, input ready);
	modport sink(input valid, input opcode, input sample, output ready);
endinterface

interface dst_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] dac_code;
	logic [8:0]  center_position;
	logic        analysed;
	logic [1:0]  moved;

	modport source(output valid, output dac_code, output center_position,
		output analysed, output moved, input ready);
	modport sink(input valid, input dac_code, input center_position,
		input analysed, input moved, output ready);
endinterface

interface dst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dst_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dst_mul #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic             done,
	output logic [A_W+B_W-1:0] prod
);
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   acc_q;
	logic [P_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= P_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- rtl/core/dst_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dst_div #(
	parameter int N_W = 28,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo
);
	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   sh_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, sh_q[N_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? D_W'(trial - {1'b0, den_q}) : trial[D_W-1:0];
			sh_q  <= {sh_q[N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// ----- rtl/core/dither_seam_tracker.sv -----
// A sample runs through the serial multiplier and then the serial divider; a first sample
// after reset or a tick is taken directly as the new mean. A tick runs the multiplier and divider for
// the DAC code (the divide is skipped when the code saturates) and again to fold the bin, and
// it adds the 20-bin sweep when it closes an analysis period.
// One item is in work at a time; a result waits in the output register.
// Reset (arst_n, asynchronous) restores the registers, phase, bins, mean and center.
// ----------------------------------------------------------------------------
// Dither seam tracker
// Sine dither scan controller with per-phase averaging and center tracking.
// ----------------------------------------------------------------------------
module dither_seam_tracker #(
	parameter int SAMPLE_BITS = 12,
	parameter int COUNT_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	dst_item_if.sink    item,
	dst_result_if.source result,
	dst_cfg_if.sink     cfg
);
	import dst_pkg::*;

	localparam int A_W   = (SAMPLE_BITS > SINE_W) ? SAMPLE_BITS : SINE_W;
	localparam int B_W   = (COUNT_BITS > AMP_W) ? COUNT_BITS : AMP_W;
	localparam int P_W   = A_W + B_W;
	localparam int SUM_W = P_W + 1;
	localparam int NUM_W = (SAMPLE_BITS + COUNT_BITS > DX_W) ? SAMPLE_BITS + COUNT_BITS : DX_W;
	localparam int D_W   = (COUNT_BITS > HIT_W) ? COUNT_BITS : HIT_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SMUL   = 4'd1;
	localparam logic [3:0] ST_SDIV   = 4'd2;
	localparam logic [3:0] ST_TMUL   = 4'd3;
	localparam logic [3:0] ST_TSAT   = 4'd4;
	localparam logic [3:0] ST_TDIV   = 4'd5;
	localparam logic [3:0] ST_FMUL   = 4'd6;
	localparam logic [3:0] ST_FDIV   = 4'd7;
	localparam logic [3:0] ST_SWEEP  = 4'd8;
	localparam logic [3:0] ST_DECIDE = 4'd9;
	localparam logic [3:0] ST_EMIT   = 4'd10;

	logic [3:0]             state_q;
	logic [AMP_W-1:0]       amp_q;
	logic [THR_W-1:0]       thr_q;
	logic [SPA_W-1:0]       spa_q;
	logic [PH_W-1:0]        phase_q;
	logic [SPA_W-1:0]       scan_q;
	logic [AVG_W-1:0]       avg_q [NPHASE];
	logic [HIT_W-1:0]       hits_q [NPHASE];
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   fresh_q;
	logic [CTR_W-1:0]       center_q;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [PH_W-1:0]        ph_q;
	logic [PH_W-1:0]        bin_q;
	logic [PH_W-1:0]        idx_q;
	logic                   sneg_q;
	logic signed [DSUM_W-1:0] dnum_q;
	logic [DAC_W-1:0]       dac_q;
	logic signed [PSUM_W-1:0] psum_q;
	logic                   an_q;
	logic [MV_W-1:0]        mv_q;

	logic [A_W-1:0]         op_a_q;
	logic [B_W-1:0]         op_b_q;
	logic                   mul_go_q;
	logic [NUM_W-1:0]       div_num_q;
	logic [D_W-1:0]         div_den_q;
	logic                   div_go_q;

	logic                   out_valid_q;
	logic [DAC_W-1:0]       out_dac_q;
	logic [CTR_W-1:0]       out_center_q;
	logic                   out_an_q;
	logic [MV_W-1:0]        out_mv_q;

	logic                   mul_done;
	logic [P_W-1:0]         mul_prod;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quo;

	dst_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_go_q),
		.a     (op_a_q),
		.b     (op_b_q),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	dst_div #(.N_W(NUM_W), .D_W(D_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Combinational helpers
	logic                     in_beat;
	logic                     out_free;
	logic [PH_W-1:0]          ph_sel;
	logic signed [SINE_W-1:0] sin_v;
	logic [SINE_W-1:0]        sin_mag;
	logic signed [DSUM_W-1:0] smag;
	logic signed [DSUM_W-1:0] sval;
	logic signed [DSUM_W-1:0] s330;
	logic signed [DSUM_W-1:0] cterm;
	logic [DX_W-1:0]          dx;
	logic [HIT_W-1:0]         fold_n;
	logic [HIT_W-1:0]         fold_d;
	logic [COUNT_BITS-1:0]    smp_d;
	logic [SUM_W-1:0]         smp_sum;
	logic [SUM_W-1:0]         fold_sum;
	logic [PH_W-1:0]          ph_next;
	logic [SPA_W-1:0]         scan_next;
	logic [PSUM_W-1:0]        p_abs;
	logic signed [AN_W-1:0]   an_val;
	logic [AN_W-1:0]          an_mag;
	logic signed [PSUM_W-1:0] bin_term;

	assign in_beat  = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign ph_sel   = (phase_q < PH_W'(NPHASE)) ? phase_q : '0;
	assign sin_v    = sine_q15(ph_sel);
	assign sin_mag  = sin_v[SINE_W-1] ? SINE_W'(-sin_v) : sin_v;

	// Signed dither term times 330 plus center * 2^27, the DAC numerator.
	assign smag  = DSUM_W'(mul_prod[SPROD_W-1:0]);
	assign sval  = sneg_q ? -smag : smag;
	assign s330  = (sval <<< 8) + (sval <<< 6) + (sval <<< 3) + (sval <<< 1);
	assign cterm = DSUM_W'(center_q) <<< 27;
	assign dx    = DX_W'(dnum_q[DSUM_W-2:15]);

	assign fold_n   = hits_q[bin_q];
	assign fold_d   = (fold_n == '0) ? HIT_W'(1) : fold_n;
	assign smp_d    = (count_q == '0) ? COUNT_BITS'(1) : count_q;
	assign smp_sum  = SUM_W'(mul_prod) + SUM_W'(sample_q);
	assign fold_sum = SUM_W'(mul_prod) + SUM_W'(mean_q);
	assign ph_next  = ph_q + 1'b1;
	assign scan_next = scan_q + 1'b1;

	assign bin_term = (idx_q < PH_HALF) ? $signed({5'b0, avg_q[idx_q]})
		: -$signed({5'b0, avg_q[idx_q]});
	assign p_abs  = psum_q[PSUM_W-1] ? PSUM_W'(-psum_q) : psum_q;
	assign an_val = $signed({6'b0, avg_q[PH_PROBE]}) - $signed({1'b0, p_abs});
	assign an_mag = an_val[AN_W-1] ? AN_W'(-an_val) : an_val;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			amp_q       <= AMP_RESET;
			thr_q       <= THR_RESET;
			spa_q       <= SPA_RESET;
			phase_q     <= '0;
			scan_q      <= '0;
			for (int i = 0; i < NPHASE; i++) begin
				avg_q[i]  <= '0;
				hits_q[i] <= HIT_W'(1);
			end
			mean_q      <= '0;
			count_q     <= COUNT_BITS'(1);
			fresh_q     <= 1'b1;
			center_q    <= CENTER_RESET;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && result.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				case (cfg.index)
					REG_AMP: amp_q <= cfg.data[AMP_W-1:0];
					REG_THR: thr_q <= cfg.data[THR_W-1:0];
					REG_SPA: spa_q <= cfg.data[SPA_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (item.opcode == OP_SAMPLE) begin
							if (fresh_q) begin
								mean_q  <= item.sample;
								count_q <= COUNT_BITS'(2);
								fresh_q <= 1'b0;
							end else begin
								mul_go_q <= 1'b1;
								state_q  <= ST_SMUL;
							end
						end else begin
							fresh_q  <= 1'b1;
							mul_go_q <= 1'b1;
							state_q  <= ST_TMUL;
						end
					end
				end
				ST_SMUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						mean_q <= div_quo[SAMPLE_BITS-1:0];
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TMUL: begin
					if (mul_done) begin
						state_q <= ST_TSAT;
					end
				end
				ST_TSAT: begin
					if (dnum_q[DSUM_W-1] || dx >= DAC_SAT_X) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_FMUL;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_FMUL;
					end
				end
				ST_FMUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						avg_q[bin_q] <= div_quo[AVG_W-1:0];
						if (fold_n != HITS_MAX) begin
							hits_q[bin_q] <= fold_n + 1'b1;
						end
						if (ph_next == PH_W'(NPHASE)) begin
							phase_q <= '0;
							if (scan_next >= spa_q) begin
								scan_q  <= '0;
								state_q <= ST_SWEEP;
							end else begin
								scan_q  <= scan_next;
								state_q <= ST_EMIT;
							end
						end else begin
							phase_q <= ph_next;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SWEEP: begin
					if (idx_q == PH_LAST) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (an_mag > AN_W'(thr_q)) begin
						if (!an_val[AN_W-1]) begin
							if (center_q < CENTER_MAX) begin
								center_q <= center_q + 1'b1;
							end
						end else if (center_q != '0) begin
							center_q <= center_q - 1'b1;
						end
					end
					for (int i = 0; i < NPHASE; i++) begin
						avg_q[i]  <= '0;
						hits_q[i] <= HIT_W'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					sample_q <= item.sample;
					if (item.opcode == OP_SAMPLE) begin
						op_a_q <= A_W'(mean_q);
						op_b_q <= B_W'(count_q - 1'b1);
					end else begin
						ph_q   <= ph_sel;
						bin_q  <= (ph_sel == '0) ? PH_LAST : ph_sel - 1'b1;
						sneg_q <= sin_v[SINE_W-1];
						op_a_q <= A_W'(sin_mag);
						op_b_q <= B_W'(amp_q);
					end
				end
			end
			ST_SMUL: begin
				div_num_q <= smp_sum[NUM_W-1:0];
				div_den_q <= D_W'(smp_d);
			end
			ST_TMUL: begin
				dnum_q <= s330 + cterm;
			end
			ST_TSAT: begin
				dac_q     <= dnum_q[DSUM_W-1] ? '0 : DAC_TOP;
				div_num_q <= NUM_W'(dx);
				div_den_q <= D_W'(DAC_DIVISOR);
				op_a_q    <= A_W'(avg_q[bin_q]);
				op_b_q    <= B_W'(fold_d - 1'b1);
			end
			ST_TDIV: begin
				if (div_done) begin
					dac_q <= div_quo[DAC_W-1:0];
				end
			end
			ST_FMUL: begin
				div_num_q <= fold_sum[NUM_W-1:0];
				div_den_q <= D_W'(fold_d);
			end
			ST_FDIV: begin
				idx_q  <= '0;
				psum_q <= '0;
				an_q   <= 1'b0;
				mv_q   <= MV_NONE;
			end
			ST_SWEEP: begin
				psum_q <= psum_q + bin_term;
				idx_q  <= idx_q + 1'b1;
			end
			ST_DECIDE: begin
				an_q <= 1'b1;
				if (an_mag > AN_W'(thr_q)) begin
					if (!an_val[AN_W-1]) begin
						mv_q <= (center_q < CENTER_MAX) ? MV_UP : MV_NONE;
					end else begin
						mv_q <= (center_q != '0) ? MV_DOWN : MV_NONE;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_dac_q    <= dac_q;
					out_center_q <= center_q;
					out_an_q     <= an_q;
					out_mv_q     <= mv_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid           = out_valid_q;
	assign result.dac_code        = out_dac_q;
	assign result.center_position = out_center_q;
	assign result.analysed        = out_an_q;
	assign result.moved           = out_mv_q;

`ifndef SYNTH
	a_center_range: assert property (@(posedge clk) disable iff (!arst_n)
		center_q <= CENTER_MAX)
		else $error("center left its range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PH_W'(NPHASE))
		else $error("phase left its range");

	a_move_needs_analysis: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.moved == MV_NONE || result.analysed))
		else $error("center step reported without analysis");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result beat raised outside the emit step");
`endif

endmodule

// ----- tb/dst_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dither seam tracker bench channels
// A control bundle used by the bench top beside the block's channel interfaces.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come from the RTL source; this file only
// holds a small bundle through which the bench asks the receiver for a long hold-off.
interface dst_tb_ctl_if;
	logic hold_results;
endinterface

// ----- tb/tb_dither_seam_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dither seam tracker testbench
// Drives samples, ticks and register writes with random gaps and stalls, and
// checks every tick result against a cycle-free model of the scan controller.
// ----------------------------------------------------------------------------
module tb_dither_seam_tracker;
	import dst_pkg::*;

	typedef struct packed {
		logic [DAC_W-1:0] dac;
		logic [CTR_W-1:0] ctr;
		logic             an;
		logic [MV_W-1:0]  mv;
	} tick_result_t;

	class tick_scoreboard;
		int unsigned amp, thr, spa;
		int unsigned ph, scans, ctr, mean, cnt;
		bit fresh;
		int unsigned avg[NPHASE];
		int unsigned hits[NPHASE];
		tick_result_t pending[$];
		int errors;

		function void reset_state();
			amp = AMP_RESET; thr = THR_RESET; spa = SPA_RESET;
			ph = 0; scans = 0; ctr = CENTER_RESET; mean = 0; cnt = 1; fresh = 1;
			foreach (avg[i]) begin
				avg[i] = 0;
				hits[i] = 1;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_AMP: amp = d[AMP_W-1:0];
				REG_THR: thr = d[THR_W-1:0];
				REG_SPA: spa = d[SPA_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned dac_of(int unsigned p);
			longint num, q;
			num = longint'(sine_q15(p[PH_W-1:0])) * amp * 330 + longint'(ctr) * 4096 * 32768;
			if (num < 0) return 0;
			q = num / (longint'(32768) * 330);
			return q > 4095 ? 4095 : int'(q);
		endfunction

		function void note_item(logic op, logic [11:0] s);
			tick_result_t r;
			int unsigned prv, d;
			longint pbal, diff, mag;
			if (op == OP_SAMPLE) begin
				if (fresh) begin
					mean = s; cnt = 2; fresh = 0;
				end else begin
					d = cnt ? cnt : 1;
					mean = (longint'(mean) * (d - 1) + s) / d;
					if (cnt < 65535) cnt++;
				end
				return;
			end
			fresh = 1;
			r = '0;
			r.dac = DAC_W'(dac_of(ph));
			prv = ph == 0 ? NPHASE - 1 : ph - 1;
			d = hits[prv] ? hits[prv] : 1;
			avg[prv] = ((longint'(avg[prv]) * (d - 1) + mean) / d) & 12'hFFF;
			if (hits[prv] < HITS_MAX) hits[prv]++;
			ph++;
			r.mv = MV_NONE;
			if (ph == NPHASE) begin
				ph = 0;
				scans = (scans + 1) & 8'hFF;
				if (scans >= spa) begin
					scans = 0;
					r.an = 1;
					pbal = 0;
					for (int i = 0; i < NPHASE; i++)
						pbal += i < 10 ? avg[i] : -longint'(avg[i]);
					if (pbal < 0) pbal = -pbal;
					diff = longint'(avg[PH_PROBE]) - pbal;
					mag = diff < 0 ? -diff : diff;
					if (mag > thr) begin
						if (diff > 0) begin
							if (ctr < CENTER_MAX) begin
								ctr++; r.mv = MV_UP;
							end
						end else if (ctr > 0) begin
							ctr--; r.mv = MV_DOWN;
						end
					end
					foreach (avg[i]) begin
						avg[i] = 0;
						hits[i] = 1;
					end
				end
			end
			r.ctr = CTR_W'(ctr);
			pending.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.dac !== exp_r.dac || got.ctr !== exp_r.ctr || got.an !== exp_r.an
					|| got.mv !== exp_r.mv) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected dac %0d ctr %0d an %0d mv %0d, got %0d %0d %0d %0d",
						exp_r.dac, exp_r.ctr, exp_r.an, exp_r.mv,
						got.dac, got.ctr, got.an, got.mv);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	dst_item_if #(.SAMPLE_BITS(12)) item();
	dst_result_if result();
	dst_cfg_if cfg();
	dst_tb_ctl_if ctl();

	dither_seam_tracker #(.SAMPLE_BITS(12), .COUNT_BITS(16)) uut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
	);

	tick_scoreboard scan_model = new();
	int idle_pct = 12;
	int stall_cycles = 0;
	int quiet_cycles = 0;
	localparam int QUIET_LIMIT = 20000;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		item.valid = 0; item.opcode = 0; item.sample = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		result.ready = 0;
		ctl.hold_results = 0;
		scan_model.reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver: random stalls, plus one long hold-off while items keep coming.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				scan_model.check_result({result.dac_code, result.center_position,
					result.analysed, result.moved});
			if (stall_cycles > 0) begin
				stall_cycles <= stall_cycles - 1;
				result.ready <= 0;
			end else if (ctl.hold_results) begin
				ctl.hold_results <= 0;
				stall_cycles <= 400;
				result.ready <= 0;
			end else
				result.ready <= $urandom_range(99) >= idle_pct;
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The valid line stays up between beats unless an idle cycle is drawn.
	task automatic send_item(logic op, logic [11:0] s);
		while ($urandom_range(99) < idle_pct) begin
			item.valid <= 0;
			@(posedge clk);
		end
		item.valid <= 1; item.opcode <= op; item.sample <= s;
		do @(posedge clk); while (!item.ready);
		scan_model.note_item(op, s);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		scan_model.write_reg(idx, d);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// A trailing sample produces no result, so allow its full latency too.
	task automatic drain();
		item.valid <= 0;
		while (scan_model.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_scan_run(int n, int spread);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 30)
				send_item(OP_TICK, 0);
			else
				send_item(OP_SAMPLE, 12'(spread ? $urandom_range(4095)
					: 2048 + $urandom_range(spread + 40) - 20));
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// Directed: field extremes, the fresh-sample restart, and saturation.
		write_reg(REG_SPA, 1);
		write_reg(REG_THR, 0);
		send_item(OP_SAMPLE, 12'hFFF);
		send_item(OP_SAMPLE, 0);
		send_item(OP_SAMPLE, 12'hFFF);
		send_item(OP_TICK, 12'hFFF);
		send_item(OP_TICK, 0);
		send_item(OP_SAMPLE, 12'h555);
		send_item(OP_SAMPLE, 12'hAAA);
		send_item(OP_TICK, 0);
		drain();
		write_reg(REG_AMP, 2047);
		for (int i = 0; i < 20; i++) send_item(OP_TICK, 0);
		drain();
		// Random phases across several register settings, extremes included.
		idle_pct = 0;
		write_reg(REG_AMP, 0); write_reg(REG_THR, 4095); write_reg(REG_SPA, 255);
		ctl.hold_results <= 1;
		random_scan_run(120, 1);
		drain();
		idle_pct = 12;
		write_reg(REG_AMP, CFG_DATA_W'($urandom_range(2047)));
		write_reg(REG_THR, CFG_DATA_W'($urandom_range(200)));
		write_reg(REG_SPA, 1);
		random_scan_run(260, 0);
		drain();
		write_reg(REG_AMP, 1500); write_reg(REG_THR, 5); write_reg(REG_SPA, 2);
		random_scan_run(250, 1);
		drain();
		if (scan_model.errors == 0 && scan_model.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
